>>> rtl/crp_pkg.sv
// shared constants for the catmull-rom point and tangent evaluator
// no dependencies; imported by the lane, merge, top and checker files
package crp_pkg;

  localparam int NUM_AXES    = 3;
  localparam int GUARD_BITS  = 12;
  localparam int LANE_STAGES = 8;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

endpackage

>>> rtl/crp_lane.sv
// one axis lane: coefficient setup, horner evaluation of point and tangent, round and clamp
// depends on crp_pkg; stage loads come from the pipeline control in the top level
module crp_lane import crp_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int PARAM_WIDTH = 16
) (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] adv,
  input  logic [PARAM_WIDTH-1:0] param_t,
  input  logic [COORD_WIDTH-1:0] ctrl_a,
  input  logic [COORD_WIDTH-1:0] ctrl_b,
  input  logic [COORD_WIDTH-1:0] ctrl_c,
  input  logic [COORD_WIDTH-1:0] ctrl_d,
  output logic [COORD_WIDTH-1:0] pos,
  output logic [COORD_WIDTH-1:0] tan,
  output logic                   clip
);

  localparam int W  = COORD_WIDTH;
  localparam int P  = PARAM_WIDTH;
  localparam int CW = W + 5;
  localparam int AW = W + GUARD_BITS + 7;
  localparam int PW = AW + P + 1;

  localparam logic signed [AW-1:0] RND    = AW'(1) <<< GUARD_BITS;
  localparam logic signed [AW-1:0] SAT_HI = AW'((2 ** (W - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [CW-1:0] cx(input logic [W-1:0] v);
    cx = CW'(signed'(v));
  endfunction

  function automatic logic signed [AW-1:0] sc(input logic signed [CW-1:0] v);
    sc = AW'(v) <<< GUARD_BITS;
  endfunction

  function automatic logic signed [P:0] tx(input logic [P-1:0] v);
    tx = signed'({1'b0, v});
  endfunction

  // halve with round to nearest, clamp to the coordinate range
  function automatic logic [W:0] fin(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] r;
    logic [W:0]           res;
    r = (acc + RND) >>> (GUARD_BITS + 1);
    if (r > SAT_HI) begin
      res = {1'b1, SAT_HI[W-1:0]};
    end else if (r < SAT_LO) begin
      res = {1'b1, SAT_LO[W-1:0]};
    end else begin
      res = {1'b0, r[W-1:0]};
    end
    fin = res;
  endfunction

  logic signed [CW-1:0] a_s, b_s, c_s, d_s;
  logic signed [CW-1:0] c1_nxt, c2_nxt, c3_nxt, b2_nxt, c3x3;
  logic signed [PW-1:0] pp1_nxt, pt1_nxt, pp3_nxt, pt3_nxt, pp5_nxt;
  logic signed [AW-1:0] ap2_nxt, at2_nxt, ap4_nxt, at4_nxt, ap6_nxt;
  logic [W:0]           fp_nxt, ft_nxt;

  logic [P-1:0]         t0_r, t1_r, t2_r, t3_r, t4_r;
  logic signed [CW-1:0] c1_0_r, c2_0_r, c3_0_r, b2_0_r;
  logic signed [CW-1:0] c1_1_r, c2_1_r, b2_1_r;
  logic signed [CW-1:0] c1_2_r, b2_2_r, c1_3_r, b2_3_r, b2_4_r, b2_5_r;
  logic signed [PW-1:0] pp1_r, pt1_r, pp3_r, pt3_r, pp5_r;
  logic signed [AW-1:0] ap2_r, at2_r, ap4_r, at4_r, at5_r, ap6_r, at6_r;
  logic [W-1:0]         pos_r, tan_r;
  logic                 clip_r;

  always_comb begin
    a_s     = cx(ctrl_a);
    b_s     = cx(ctrl_b);
    c_s     = cx(ctrl_c);
    d_s     = cx(ctrl_d);
    c1_nxt  = c_s - a_s;
    c2_nxt  = (a_s <<< 1) - ((b_s <<< 2) + b_s) + (c_s <<< 2) - d_s;
    c3_nxt  = ((b_s - c_s) <<< 1) + (b_s - c_s) + d_s - a_s;
    b2_nxt  = b_s <<< 1;
    c3x3    = (c3_0_r <<< 1) + c3_0_r;
    pp1_nxt = PW'(sc(c3_0_r)) * PW'(tx(t0_r));
    pt1_nxt = PW'(sc(c3x3)) * PW'(tx(t0_r));
    ap2_nxt = AW'(pp1_r >>> P) + sc(c2_1_r);
    at2_nxt = AW'(pt1_r >>> P) + sc(c2_1_r <<< 1);
    pp3_nxt = PW'(ap2_r) * PW'(tx(t2_r));
    pt3_nxt = PW'(at2_r) * PW'(tx(t2_r));
    ap4_nxt = AW'(pp3_r >>> P) + sc(c1_3_r);
    at4_nxt = AW'(pt3_r >>> P) + sc(c1_3_r);
    pp5_nxt = PW'(ap4_r) * PW'(tx(t4_r));
    ap6_nxt = AW'(pp5_r >>> P) + sc(b2_5_r);
    fp_nxt  = fin(ap6_r);
    ft_nxt  = fin(at6_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t0_r   <= param_t;
      c1_0_r <= c1_nxt;
      c2_0_r <= c2_nxt;
      c3_0_r <= c3_nxt;
      b2_0_r <= b2_nxt;
    end
    if (adv[1]) begin
      pp1_r  <= pp1_nxt;
      pt1_r  <= pt1_nxt;
      t1_r   <= t0_r;
      c1_1_r <= c1_0_r;
      c2_1_r <= c2_0_r;
      b2_1_r <= b2_0_r;
    end
    if (adv[2]) begin
      ap2_r  <= ap2_nxt;
      at2_r  <= at2_nxt;
      t2_r   <= t1_r;
      c1_2_r <= c1_1_r;
      b2_2_r <= b2_1_r;
    end
    if (adv[3]) begin
      pp3_r  <= pp3_nxt;
      pt3_r  <= pt3_nxt;
      t3_r   <= t2_r;
      c1_3_r <= c1_2_r;
      b2_3_r <= b2_2_r;
    end
    if (adv[4]) begin
      ap4_r  <= ap4_nxt;
      at4_r  <= at4_nxt;
      t4_r   <= t3_r;
      b2_4_r <= b2_3_r;
    end
    if (adv[5]) begin
      pp5_r  <= pp5_nxt;
      at5_r  <= at4_r;
      b2_5_r <= b2_4_r;
    end
    if (adv[6]) begin
      ap6_r <= ap6_nxt;
      at6_r <= at5_r;
    end
    if (adv[7]) begin
      pos_r  <= fp_nxt[W-1:0];
      tan_r  <= ft_nxt[W-1:0];
      clip_r <= fp_nxt[W] | ft_nxt[W];
    end
  end

  assign pos  = pos_r;
  assign tan  = tan_r;
  assign clip = clip_r;

endmodule

>>> rtl/crp_merge.sv
// merge stage: packs the lane results into one beat and combines the clamp flags
// depends on crp_pkg; holds the output register of the block
module crp_merge import crp_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic [COORD_WIDTH-1:0]          pos [NUM_AXES],
  input  logic [COORD_WIDTH-1:0]          tan [NUM_AXES],
  input  logic [NUM_AXES-1:0]             clip,
  output logic [2*NUM_AXES*COORD_WIDTH-1:0] out_data,
  output logic                            out_clip
);

  localparam int W = COORD_WIDTH;

  logic [2*NUM_AXES*W-1:0] data_nxt, data_r;
  logic                    clip_r;

  always_comb begin
    data_nxt = '0;
    for (int g = 0; g < NUM_AXES; g++) begin
      data_nxt[g*W +: W]              = pos[g];
      data_nxt[(NUM_AXES + g)*W +: W] = tan[g];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      clip_r <= |clip;
    end
  end

  assign out_data = data_r;
  assign out_clip = clip_r;

endmodule

>>> rtl/catmull_rom_point_tangent.sv
// top level of the catmull-rom point and tangent evaluator
// depends on crp_pkg, crp_lane and crp_merge
//
//   channel  dir  payload
//   in_      in   tdata: param_t, ctrl_a, ctrl_b, ctrl_c, ctrl_d
//   out_     out  tdata: pos_x..z, tan_x..z; tuser: clipped
//
// one beat per cycle sustained while out_tready is high; the path from input beat to output beat
// runs through coefficient setup, the three multiply and add stage pairs of the horner chain,
// round and clamp in each axis lane, and the merge register
// every stage has its own valid bit, so bubbles close up while the output stalls
// reset clears the valid bits only; in_tready is low while rst_n is low
module catmull_rom_point_tangent import crp_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int PARAM_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // param_t, ctrl_a, ctrl_b, ctrl_c, ctrl_d (x, y, z each), zero pad
  input  logic [((PARAM_WIDTH + 4*NUM_AXES*COORD_WIDTH + 7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, zero pad
  output logic [((2*NUM_AXES*COORD_WIDTH + 7)/8)*8-1:0] out_tdata,
  // clipped
  output logic out_tuser
);

  localparam int W     = COORD_WIDTH;
  localparam int OUT_W = ((2*NUM_AXES*W + 7)/8)*8;
  localparam int PT    = PARAM_WIDTH;

  logic [PIPE_STAGES-1:0] vld_r, vld_nxt, rdy, adv;
  logic [W-1:0]           pos_w [NUM_AXES];
  logic [W-1:0]           tan_w [NUM_AXES];
  logic [NUM_AXES-1:0]    clip_w;
  logic [2*NUM_AXES*W-1:0] merge_data;
  logic                   merge_clip;

  always_comb begin
    rdy[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || out_tready;
    for (int k = PIPE_STAGES-2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    in_tready  = rdy[0] && rst_n;
    adv[0]     = in_tvalid && in_tready;
    vld_nxt[0] = rdy[0] ? adv[0] : vld_r[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      adv[k]     = rdy[k] && vld_r[k-1];
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    crp_lane #(
      .COORD_WIDTH(COORD_WIDTH),
      .PARAM_WIDTH(PARAM_WIDTH)
    ) u_lane (
      .clk     (clk),
      .adv     (adv[LANE_STAGES-1:0]),
      .param_t (in_tdata[PT-1:0]),
      .ctrl_a  (in_tdata[PT + (0*NUM_AXES + g)*W +: W]),
      .ctrl_b  (in_tdata[PT + (1*NUM_AXES + g)*W +: W]),
      .ctrl_c  (in_tdata[PT + (2*NUM_AXES + g)*W +: W]),
      .ctrl_d  (in_tdata[PT + (3*NUM_AXES + g)*W +: W]),
      .pos     (pos_w[g]),
      .tan     (tan_w[g]),
      .clip    (clip_w[g])
    );
  end

  crp_merge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_merge (
    .clk      (clk),
    .load     (adv[PIPE_STAGES-1]),
    .pos      (pos_w),
    .tan      (tan_w),
    .clip     (clip_w),
    .out_data (merge_data),
    .out_clip (merge_clip)
  );

  assign out_tvalid = vld_r[PIPE_STAGES-1];
  assign out_tdata  = OUT_W'(merge_data);
  assign out_tuser  = merge_clip;

endmodule

>>> rtl/crp_checker.sv
// port-level checks for the catmull-rom evaluator, bound to the top level
// depends on crp_pkg and catmull_rom_point_tangent
module crp_checker import crp_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int PARAM_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((PARAM_WIDTH + 4*NUM_AXES*COORD_WIDTH + 7)/8)*8-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((2*NUM_AXES*COORD_WIDTH + 7)/8)*8-1:0] out_tdata,
  input logic out_tuser
);

  localparam int CNT_W = $clog2(PIPE_STAGES + 1);

  logic [CNT_W-1:0] fill_r, fill_nxt, run_r, run_nxt;
  logic             in_beat, out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  always_comb begin
    fill_nxt = fill_r + CNT_W'(in_beat) - CNT_W'(out_beat);
    if (!out_tready) begin
      run_nxt = '0;
    end else if (run_r != CNT_W'(PIPE_STAGES)) begin
      run_nxt = run_r + CNT_W'(1);
    end else begin
      run_nxt = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      run_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      run_r  <= run_nxt;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input beat withdrawn or changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fill_r != '0) && (fill_r <= CNT_W'(PIPE_STAGES)))
    else $error("output beat without a matching input beat in flight");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_beat, PIPE_STAGES) && (run_r >= CNT_W'(PIPE_STAGES - 1)) |-> out_tvalid)
    else $error("result late although the output was never stalled");

endmodule

bind catmull_rom_point_tangent crp_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .PARAM_WIDTH(PARAM_WIDTH)
) u_crp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
